FILE: hdl/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, character codes and helper functions for the string escape
// decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

  localparam int CHAR_W         = 8;
  localparam int HELD_DEPTH     = 6;
  localparam int MAX_HEX_DIGITS = 6;
  localparam int HCNT_W         = 3;
  localparam int CP_W           = 24;
  localparam int PRE_DEPTH      = 8;
  localparam int SUF_DEPTH      = 4;
  localparam int RUN_DEPTH      = 9;
  localparam int RUN_CNT_W      = 4;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BSL,
    MODE_XHEX,
    MODE_UOPEN,
    MODE_UDIG
  } esc_mode_t;

  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;

  localparam logic [CP_W-1:0] CP_MAX     = 24'h10FFFF;
  localparam logic [CP_W-1:0] CP_REPL    = 24'h00FFFD;
  localparam logic [CP_W-1:0] SURR_LO    = 24'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 24'h00DFFF;
  localparam logic [CP_W-1:0] UTF8_1_MAX = 24'h00007F;
  localparam logic [CP_W-1:0] UTF8_2_MAX = 24'h0007FF;
  localparam logic [CP_W-1:0] UTF8_3_MAX = 24'h00FFFF;
  localparam logic [7:0]      LEAD_2     = 8'hC0;
  localparam logic [7:0]      LEAD_3     = 8'hE0;
  localparam logic [7:0]      LEAD_4     = 8'hF0;
  localparam logic [7:0]      CONT_MARK  = 8'h80;

  typedef struct packed {
    logic [SUF_DEPTH-1:0][CHAR_W-1:0] bytes;
    logic [2:0]                       len;
  } utf8_t;

  function automatic logic is_hex(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOW_A && c <= CH_LOW_F) ||
           (c >= CH_UP_A && c <= CH_UP_F);
  endfunction

  // valid for hex digits only
  function automatic logic [3:0] hex_val(input logic [CHAR_W-1:0] c);
    return (c <= CH_NINE) ? c[3:0] : 4'(c[3:0] + 4'd9);
  endfunction

  function automatic utf8_t utf8_encode(input logic [CP_W-1:0] cp_in);
    logic [CP_W-1:0] cp;
    utf8_t           r;
    cp = cp_in;
    if (cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
      cp = CP_REPL;
    end
    r.bytes = '0;
    if (cp <= UTF8_1_MAX) begin
      r.bytes[0] = cp[7:0];
      r.len      = 3'd1;
    end else if (cp <= UTF8_2_MAX) begin
      r.bytes[0] = LEAD_2 | {3'b000, cp[10:6]};
      r.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
      r.len      = 3'd2;
    end else if (cp <= UTF8_3_MAX) begin
      r.bytes[0] = LEAD_3 | {4'b0000, cp[15:12]};
      r.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
      r.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
      r.len      = 3'd3;
    end else begin
      r.bytes[0] = LEAD_4 | {5'b00000, cp[20:18]};
      r.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
      r.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
      r.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
      r.len      = 3'd4;
    end
    return r;
  endfunction

endpackage

FILE: hdl/escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Streaming decoder for string-literal bodies: escapes, \xHH and \u{...}
// with UTF-8 encoding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one body byte per item on
//   in_char_in, with in_final_byte set on the last byte of the string.
//   Result channel (out_valid / out_stall): one decoded byte per item on
//   out_char_out. out_run_last marks the last byte caused by one input item,
//   out_string_done the last byte of the whole string.
//   An input item is decoded in the cycle it is accepted; its bytes (0 to 9)
//   go into a run buffer and the first one shows on the outputs in the next
//   cycle.
//   Throughput: one input item per cycle while each item gives at most one
//   byte and the receiver does not stall. An item that gives more bytes holds
//   the single output byte lane; the next item is taken in the cycle its last
//   byte is taken. Items that only extend a pending escape give no bytes and
//   pass at one per cycle.
//   When the receiver stalls, the current byte holds and the input stalls
//   once the run buffer holds its last byte.
//   Reset (rst_n low, synchronous) returns the escape state to idle, empties
//   the run buffer and stalls the input for that cycle.
// ----------------------------------------------------------------------------
module escape_sequence_decoder
  import esd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char_in,
  input  logic              in_final_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_run_last,
  output logic              out_string_done
);

  // escape state
  esc_mode_t                      mode_r, mode_nxt;
  logic [HCNT_W-1:0]              hcnt_r, hcnt_nxt;
  logic [CP_W-1:0]                cp_r, cp_nxt;
  logic [HELD_DEPTH-1:0][CHAR_W-1:0] held_r;

  // run buffer
  logic [RUN_DEPTH-1:0][CHAR_W-1:0] run_r, run_nxt;
  logic [RUN_CNT_W-1:0]             run_cnt_r, run_cnt_nxt;
  logic                             run_fin_r;

  logic              in_acc, out_acc;
  logic [CHAR_W-1:0] c;
  logic              fin;
  logic              hexc;
  logic [3:0]        hexv;
  logic              hold_digit;
  logic [HCNT_W-1:0] hcnt_inc;
  logic [CP_W-1:0]   cp_shift;
  logic              x_done, u_done, malformed, idle_path, goes_bsl, start_esc;
  esc_mode_t         step_mode;
  logic [HCNT_W-1:0] step_hcnt;
  logic [CP_W-1:0]   step_cp;
  logic              fin_flush;

  esc_mode_t                          pre_mode;
  logic [HCNT_W-1:0]                  pre_hcnt;
  logic                               pre_en;
  logic [HELD_DEPTH-1:0][CHAR_W-1:0]  held_view;
  logic [PRE_DEPTH-1:0][CHAR_W-1:0]   pre_b;
  logic [RUN_CNT_W-1:0]               pre_len;
  logic [SUF_DEPTH-1:0][CHAR_W-1:0]   suf_b;
  logic [RUN_CNT_W-1:0]               suf_len;
  utf8_t                              utf8;

  assign c        = in_char_in;
  assign fin      = in_final_byte;
  assign in_stall = !rst_n || (run_cnt_r > RUN_CNT_W'(1)) ||
                    ((run_cnt_r == RUN_CNT_W'(1)) && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  assign hexc     = is_hex(c);
  assign hexv     = hex_val(c);
  assign hcnt_inc = HCNT_W'(hcnt_r + HCNT_W'(1));
  assign cp_shift = {cp_r[CP_W-5:0], hexv};

  assign hold_digit = hexc && ((mode_r == MODE_XHEX) ||
                      ((mode_r == MODE_UDIG) && (hcnt_r < HCNT_W'(MAX_HEX_DIGITS))));
  assign x_done     = (mode_r == MODE_XHEX) && hexc && (hcnt_inc >= HCNT_W'(2));
  assign u_done     = (mode_r == MODE_UDIG) && !hold_digit && (c == CH_RBRACE) &&
                      (hcnt_r != '0);
  assign malformed  = ((mode_r == MODE_XHEX) && !hexc) ||
                      ((mode_r == MODE_UOPEN) && (c != CH_LBRACE)) ||
                      ((mode_r == MODE_UDIG) && !hold_digit && !u_done);
  assign idle_path  = (mode_r == MODE_IDLE) || (mode_r > MODE_UDIG) || malformed;
  assign goes_bsl   = idle_path && (c == CH_BSL) && !fin;
  assign start_esc  = ((mode_r == MODE_BSL) && (c == CH_X)) ||
                      ((mode_r == MODE_UOPEN) && (c == CH_LBRACE));

  // next state
  always_comb begin
    unique case (mode_r)
      MODE_IDLE: begin
        step_mode = goes_bsl ? MODE_BSL : MODE_IDLE;
      end
      MODE_BSL: begin
        if (c == CH_X) begin
          step_mode = MODE_XHEX;
        end else if (c == CH_U) begin
          step_mode = MODE_UOPEN;
        end else begin
          step_mode = MODE_IDLE;
        end
      end
      MODE_XHEX: begin
        if (hexc) begin
          step_mode = x_done ? MODE_IDLE : MODE_XHEX;
        end else begin
          step_mode = goes_bsl ? MODE_BSL : MODE_IDLE;
        end
      end
      MODE_UOPEN: begin
        if (c == CH_LBRACE) begin
          step_mode = MODE_UDIG;
        end else begin
          step_mode = goes_bsl ? MODE_BSL : MODE_IDLE;
        end
      end
      MODE_UDIG: begin
        if (hold_digit) begin
          step_mode = MODE_UDIG;
        end else if (u_done) begin
          step_mode = MODE_IDLE;
        end else begin
          step_mode = goes_bsl ? MODE_BSL : MODE_IDLE;
        end
      end
      default: begin
        step_mode = goes_bsl ? MODE_BSL : MODE_IDLE;
      end
    endcase

    if (start_esc || x_done || u_done || malformed) begin
      step_hcnt = '0;
      step_cp   = '0;
    end else if (hold_digit) begin
      step_hcnt = hcnt_inc;
      step_cp   = cp_shift;
    end else begin
      step_hcnt = hcnt_r;
      step_cp   = cp_r;
    end

    fin_flush = fin && (step_mode != MODE_IDLE);
    if (fin_flush) begin
      mode_nxt = MODE_IDLE;
      hcnt_nxt = '0;
      cp_nxt   = '0;
    end else begin
      mode_nxt = step_mode;
      hcnt_nxt = step_hcnt;
      cp_nxt   = step_cp;
    end
  end

  // outputs: literal flush prefix, then decoded suffix bytes
  always_comb begin
    utf8 = utf8_encode(cp_r);

    for (int k = 0; k < HELD_DEPTH; k++) begin
      held_view[k] = (hold_digit && (hcnt_r == HCNT_W'(k))) ? c : held_r[k];
    end

    if (malformed) begin
      pre_en   = 1'b1;
      pre_mode = mode_r;
      pre_hcnt = hcnt_r;
    end else begin
      pre_en   = fin_flush;
      pre_mode = step_mode;
      pre_hcnt = step_hcnt;
    end

    pre_b   = '0;
    pre_len = '0;
    if (pre_en) begin
      unique case (pre_mode)
        MODE_XHEX: begin
          pre_b[0] = CH_X;
          for (int k = 0; k < HELD_DEPTH; k++) begin
            pre_b[k+1] = held_view[k];
          end
          pre_len = RUN_CNT_W'(pre_hcnt) + RUN_CNT_W'(1);
        end
        MODE_UOPEN: begin
          pre_b[0] = CH_U;
          pre_len  = RUN_CNT_W'(1);
        end
        MODE_UDIG: begin
          pre_b[0] = CH_U;
          pre_b[1] = CH_LBRACE;
          for (int k = 0; k < HELD_DEPTH; k++) begin
            pre_b[k+2] = held_view[k];
          end
          pre_len = RUN_CNT_W'(pre_hcnt) + RUN_CNT_W'(2);
        end
        MODE_BSL: begin
          pre_b[0] = CH_BSL;
          pre_len  = RUN_CNT_W'(1);
        end
        default: begin
          pre_len = '0;
        end
      endcase
    end

    suf_b   = '0;
    suf_len = '0;
    if (idle_path) begin
      if (!goes_bsl) begin
        suf_b[0] = c;
        suf_len  = RUN_CNT_W'(1);
      end
    end else if (mode_r == MODE_BSL) begin
      suf_len = RUN_CNT_W'(1);
      unique case (c) inside
        CH_X, CH_U: suf_len  = '0;
        CH_N:       suf_b[0] = CH_LF;
        CH_T:       suf_b[0] = CH_TAB;
        CH_R:       suf_b[0] = CH_CR;
        CH_ZERO:    suf_b[0] = CH_NUL;
        default:    suf_b[0] = c;
      endcase
    end else if (x_done) begin
      suf_b[0] = cp_shift[7:0];
      suf_len  = RUN_CNT_W'(1);
    end else if (u_done) begin
      suf_b   = utf8.bytes;
      suf_len = RUN_CNT_W'(utf8.len);
    end
  end

  // merge prefix and suffix into the run
  always_comb begin
    logic [RUN_CNT_W-1:0] j;
    j = '0;
    for (int i = 0; i < RUN_DEPTH; i++) begin
      j = RUN_CNT_W'(i) - pre_len;
      if (RUN_CNT_W'(i) < pre_len) begin
        run_nxt[i] = pre_b[i[2:0]];
      end else if (j < RUN_CNT_W'(SUF_DEPTH)) begin
        run_nxt[i] = suf_b[j[1:0]];
      end else begin
        run_nxt[i] = '0;
      end
    end
    run_cnt_nxt = pre_len + suf_len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hcnt_r    <= '0;
      cp_r      <= '0;
      run_cnt_r <= '0;
      run_fin_r <= 1'b0;
    end else if (in_acc) begin
      mode_r    <= mode_nxt;
      hcnt_r    <= hcnt_nxt;
      cp_r      <= cp_nxt;
      run_cnt_r <= run_cnt_nxt;
      run_fin_r <= fin;
    end else if (out_acc) begin
      run_cnt_r <= RUN_CNT_W'(run_cnt_r - RUN_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      run_r <= run_nxt;
      if (hold_digit && (hcnt_r < HCNT_W'(HELD_DEPTH))) begin
        held_r[hcnt_r] <= c;
      end
    end else if (out_acc) begin
      for (int i = 0; i < RUN_DEPTH - 1; i++) begin
        run_r[i] <= run_r[i+1];
      end
    end
  end

  assign out_valid       = (run_cnt_r != '0);
  assign out_char_out    = run_r[0];
  assign out_run_last    = (run_cnt_r == RUN_CNT_W'(1));
  assign out_string_done = out_run_last && run_fin_r;

endmodule

FILE: hdl/esd_checker.sv
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks for the string escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module esd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_char_in,
  input logic       in_final_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char_out,
  input logic       out_run_last,
  input logic       out_string_done
);

  // a stalled item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_out) &&
                               $stable(out_run_last) && $stable(out_string_done))
    else $error("stalled result item changed");

  // a stalled input item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_char_in) && $stable(in_final_byte))
    else $error("stalled input item changed");

  // the last byte of a string always produces at least one item next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_final_byte |=> out_valid)
    else $error("final byte gave no result item");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_done |-> out_run_last)
    else $error("string done without end of run");

  // a run still draining holds off the input
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> in_stall)
    else $error("input taken while run pending");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_char_in      (in_char_in),
  .in_final_byte   (in_final_byte),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_char_out    (out_char_out),
  .out_run_last    (out_run_last),
  .out_string_done (out_string_done)
);

FILE: sim/tb_escape_sequence_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escape_sequence_decoder
// Drives string bodies through the escape decoder byte by byte and checks
// every decoded byte against a behavioural decoder kept in the bench. The
// stimulus runs a few hand-picked strings first, then random strings built
// mostly from well-formed escapes, with malformed escapes, cut-short strings
// and raw noise mixed in. Both channels idle at random, with a calm stretch
// and one long output hold-off that backs the decoder up.
// ----------------------------------------------------------------------------
module tb_escape_sequence_decoder;
  import esd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int HOLDOFF_AT     = 120;
  localparam int CALM_FROM      = 250;
  localparam int CALM_TO        = 330;
  localparam int DRAIN_CYCLES   = 20;
  localparam int BODY_TARGET    = 470;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } body_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              run_last;
    logic              string_done;
  } out_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] in_char_in = '0;
  logic              in_final_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CHAR_W-1:0] out_char_out;
  logic              out_run_last;
  logic              out_string_done;

  body_item_t        body_bytes[$];
  logic [CHAR_W-1:0] text[$];
  out_byte_t         expected_bytes[$];
  logic [CHAR_W-1:0] run[$];

  esc_mode_t         dec_mode = MODE_IDLE;
  logic [CHAR_W-1:0] held[HELD_DEPTH];
  int                held_n = 0;
  logic [CP_W-1:0]   cp_acc = '0;

  int                accepted_items = 0;
  int                errors = 0;
  int                holdoff_left = 0;
  bit                holdoff_done = 1'b0;
  int                quiet_cycles = 0;
  body_item_t        drive_item;
  logic              calm;

  assign calm = accepted_items >= CALM_FROM && accepted_items < CALM_TO;

  escape_sequence_decoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_in     (in_char_in),
    .in_final_byte  (in_final_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_out   (out_char_out),
    .out_run_last   (out_run_last),
    .out_string_done(out_string_done)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit is_hex_char(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOW_A && c <= CH_LOW_F) ||
           (c >= CH_UP_A && c <= CH_UP_F);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] lc;
    if (c <= CH_NINE) begin
      return 4'(c - CH_ZERO);
    end
    lc = c | 8'h20;
    return 4'(lc - CH_LOW_A + 8'd10);
  endfunction

  // queue appends
  task automatic put_run(input logic [CHAR_W-1:0] b);
    run.insert(run.size(), b);
  endtask

  task automatic put_text(input logic [CHAR_W-1:0] b);
    text.insert(text.size(), b);
  endtask

  // ---- behavioural decoder ----
  task automatic hold_digit(input logic [CHAR_W-1:0] c);
    held[held_n] = c;
    held_n++;
    cp_acc = {cp_acc[CP_W-5:0], nibble_of(c)};
  endtask

  task automatic flush_escape();
    case (dec_mode)
      MODE_BSL: put_run(CH_BSL);
      MODE_XHEX: begin
        put_run(CH_X);
        for (int k = 0; k < held_n; k++) put_run(held[k]);
      end
      MODE_UOPEN: put_run(CH_U);
      MODE_UDIG: begin
        put_run(CH_U);
        put_run(CH_LBRACE);
        for (int k = 0; k < held_n; k++) put_run(held[k]);
      end
      default: ;
    endcase
    dec_mode = MODE_IDLE;
    held_n   = 0;
    cp_acc   = '0;
  endtask

  task automatic decode_byte(input logic [CHAR_W-1:0] c, input logic fin);
    bit              from_idle;
    bit              flush_first;
    logic [CP_W-1:0] v;
    out_byte_t       ob;
    from_idle   = 1'b0;
    flush_first = 1'b0;
    run.delete();
    case (dec_mode)
      MODE_BSL: begin
        dec_mode = MODE_IDLE;
        case (c)
          CH_X: begin
            dec_mode = MODE_XHEX;
            held_n   = 0;
            cp_acc   = '0;
          end
          CH_U:    dec_mode = MODE_UOPEN;
          CH_N:    put_run(CH_LF);
          CH_T:    put_run(CH_TAB);
          CH_R:    put_run(CH_CR);
          CH_ZERO: put_run(CH_NUL);
          default: put_run(c);
        endcase
      end
      MODE_XHEX: begin
        if (is_hex_char(c)) begin
          hold_digit(c);
          if (held_n >= 2) begin
            put_run(cp_acc[7:0]);
            dec_mode = MODE_IDLE;
            held_n   = 0;
            cp_acc   = '0;
          end
        end else begin
          flush_first = 1'b1;
        end
      end
      MODE_UOPEN: begin
        if (c == CH_LBRACE) begin
          dec_mode = MODE_UDIG;
          held_n   = 0;
          cp_acc   = '0;
        end else begin
          flush_first = 1'b1;
        end
      end
      MODE_UDIG: begin
        if (is_hex_char(c) && held_n < MAX_HEX_DIGITS) begin
          hold_digit(c);
        end else if (c == CH_RBRACE && held_n > 0) begin
          v = cp_acc;
          if (v > CP_MAX || (v >= SURR_LO && v <= SURR_HI)) v = CP_REPL;
          if (v <= UTF8_1_MAX) begin
            put_run(v[7:0]);
          end else if (v <= UTF8_2_MAX) begin
            put_run({3'b110, v[10:6]});
            put_run({2'b10, v[5:0]});
          end else if (v <= UTF8_3_MAX) begin
            put_run({4'b1110, v[15:12]});
            put_run({2'b10, v[11:6]});
            put_run({2'b10, v[5:0]});
          end else begin
            put_run({5'b11110, v[20:18]});
            put_run({2'b10, v[17:12]});
            put_run({2'b10, v[11:6]});
            put_run({2'b10, v[5:0]});
          end
          dec_mode = MODE_IDLE;
          held_n   = 0;
          cp_acc   = '0;
        end else begin
          flush_first = 1'b1;
        end
      end
      default: begin
        dec_mode  = MODE_IDLE;
        from_idle = 1'b1;
      end
    endcase
    if (flush_first) flush_escape();
    if (flush_first || from_idle) begin
      if (c == CH_BSL && !fin) dec_mode = MODE_BSL;
      else put_run(c);
    end
    if (fin && dec_mode != MODE_IDLE) flush_escape();
    for (int k = 0; k < run.size(); k++) begin
      ob.ch          = run[k];
      ob.run_last    = (k == run.size() - 1);
      ob.string_done = (k == run.size() - 1) && fin;
      expected_bytes.insert(expected_bytes.size(), ob);
    end
  endtask

  // ---- stimulus building ----
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + CHAR_W'(v);
    return ($urandom_range(1) ? CH_UP_A : CH_LOW_A) + CHAR_W'(v) - 8'd10;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_nonhex();
    logic [CHAR_W-1:0] b;
    do b = CHAR_W'($urandom_range(255)); while (is_hex_char(b));
    return b;
  endfunction

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) put_text(s[i]);
  endtask

  task automatic close_string(input bit may_cut);
    body_item_t it;
    int         cut;
    if (may_cut && $urandom_range(9) == 0 && text.size() > 1) begin
      cut = $urandom_range(1, (text.size() > 3) ? 3 : text.size() - 1);
      repeat (cut) void'(text.pop_back());
    end
    for (int i = 0; i < text.size(); i++) begin
      it.ch  = text[i];
      it.fin = (i == text.size() - 1);
      body_bytes.insert(body_bytes.size(), it);
    end
    text.delete();
  endtask

  task automatic add_token();
    logic [CP_W-1:0] cp;
    int              ndig;
    case ($urandom_range(9)) inside
      0, 1: put_text(CHAR_W'($urandom_range(255)));
      2: begin
        put_text(CH_BSL);
        case ($urandom_range(4))
          0:       put_text(CH_N);
          1:       put_text(CH_T);
          2:       put_text(CH_R);
          3:       put_text(CH_ZERO);
          default: put_text(CHAR_W'($urandom_range(255)));
        endcase
      end
      3: begin
        put_text(CH_BSL);
        put_text(CH_X);
        put_text(hex_char(4'($urandom_range(15))));
        put_text(hex_char(4'($urandom_range(15))));
      end
      4, 5, 6: begin
        case ($urandom_range(5))
          0:       cp = CP_W'($urandom_range(32'h7F));
          1:       cp = CP_W'($urandom_range(32'h7FF, 32'h80));
          2:       cp = CP_W'($urandom_range(32'hFFFF, 32'h800));
          3:       cp = CP_W'($urandom_range(32'h10FFFF, 32'h10000));
          4:       cp = CP_W'($urandom_range(32'hDFFF, 32'hD800));
          default: cp = CP_W'($urandom_range(32'hFFFFFF, 32'h110000));
        endcase
        ndig = 1;
        while (ndig < MAX_HEX_DIGITS && (cp >> (4 * ndig)) != 0) ndig++;
        if ($urandom_range(3) == 0) ndig = $urandom_range(MAX_HEX_DIGITS, ndig);
        add_str("\\u{");
        for (int i = ndig - 1; i >= 0; i--) put_text(hex_char(cp[i*4 +: 4]));
        put_text(CH_RBRACE);
      end
      7: begin
        add_str("\\x");
        if ($urandom_range(1)) put_text(hex_char(4'($urandom_range(15))));
        put_text(rand_nonhex());
      end
      8: begin
        put_text(CH_BSL);
        put_text(CH_U);
        case ($urandom_range(3))
          0: put_text(CHAR_W'($urandom_range(255)));
          1: put_text(CH_LBRACE);
          2: begin
            put_text(CH_LBRACE);
            repeat ($urandom_range(0, 5)) put_text(hex_char(4'($urandom_range(15))));
            put_text(rand_nonhex());
          end
          default: begin
            put_text(CH_LBRACE);
            repeat (MAX_HEX_DIGITS + 1) put_text(hex_char(4'($urandom_range(15))));
          end
        endcase
      end
      default: repeat ($urandom_range(1, 3)) put_text(CHAR_W'($urandom_range(255)));
    endcase
  endtask

  initial begin
    // extremes, trailing backslash, escapes, bad \x, longest run, flush of \u{
    put_text(8'h00);
    close_string(1'b0);
    put_text(8'hFF);
    put_text(CH_BSL);
    close_string(1'b0);
    add_str("\\0\\q");
    close_string(1'b0);
    add_str("\\x4z");
    close_string(1'b0);
    add_str("\\u{1234567");
    close_string(1'b0);
    add_str("\\u{");
    close_string(1'b0);
    while (body_bytes.size() < BODY_TARGET) begin
      repeat ($urandom_range(1, 8)) add_token();
      close_string(1'b1);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (body_bytes.size() != 0 || in_valid || expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // ---- sender ----
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (body_bytes.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
        drive_item = body_bytes.pop_front();
        in_valid      <= 1'b1;
        in_char_in    <= drive_item.ch;
        in_final_byte <= drive_item.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---- receiver ----
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && accepted_items >= HOLDOFF_AT) begin
      holdoff_done <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 25);
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    out_byte_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("char_out: expected nothing, got %02h", out_char_out);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_char_out !== want.ch) begin
            $error("char_out: expected %02h, got %02h", want.ch, out_char_out);
            errors++;
          end
          if (out_run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_run_last);
            errors++;
          end
          if (out_string_done !== want.string_done) begin
            $error("string_done: expected %0b, got %0b", want.string_done, out_string_done);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_byte(in_char_in, in_final_byte);
        accepted_items <= accepted_items + 1;
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: sim.f
hdl/esd_pkg.sv
hdl/escape_sequence_decoder.sv
hdl/esd_checker.sv
sim/tb_escape_sequence_decoder.sv
